// ----- rtl/core/pre_pkg.sv -----
// ----------------------------------------------------------------------------
// pre_pkg
// Types and constants shared by the printable run extractor modules.
// ----------------------------------------------------------------------------
package pre_pkg;

	localparam int MAX_MIN_LEN = 32;
	localparam int RUN_IDX_W   = $clog2(MAX_MIN_LEN);
	localparam int RUN_CNT_W   = RUN_IDX_W + 1;
	localparam int CFG_W       = 6;
	localparam int CMDQ_DEPTH  = 4;
	localparam int CMDQ_PTR_W  = 2;
	localparam int OUTQ_DEPTH  = 4;
	localparam int OUTQ_PTR_W  = 2;

	localparam logic [CFG_W-1:0] DEF_MIN_LEN  = CFG_W'(4);
	localparam logic [7:0]       TAB_CHAR     = 8'h09;
	localparam logic [7:0]       NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0]       PRINT_LO     = 8'h20;
	localparam logic [7:0]       PRINT_HI     = 8'h7E;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_EOF  = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        string_start;
		logic [31:0] string_offset;
		logic        last;
	} out_item_t;

	typedef enum logic [1:0] {
		K_WRITE,
		K_FLUSH,
		K_PASS,
		K_NL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [7:0]             data;
		logic [RUN_IDX_W-1:0]   idx;
		logic [RUN_CNT_W-1:0]   count;
		logic [31:0]            offset;
	} work_cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_FLUSH
	} back_state_t;

endpackage

// ----- rtl/core/pre_front.sv -----
// ----------------------------------------------------------------------------
// pre_front
// Classifies input bytes, tracks run length and offset, issues work commands.
// ----------------------------------------------------------------------------
module pre_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic [pre_pkg::CFG_W-1:0] cfg_data,
	input  logic                    push,
	input  pre_pkg::in_item_t       item,
	input  logic                    cq_full,
	output logic                    cq_push,
	output pre_pkg::work_cmd_t      cq_data
);
	import pre_pkg::*;

	logic [CFG_W-1:0]     min_length_q;
	logic [RUN_CNT_W-1:0] run_count_q;
	logic                 emitting_q;
	logic [31:0]          byte_offset_q;

	logic [RUN_CNT_W-1:0] run_count_d;
	logic                 emitting_d;
	logic [31:0]          byte_offset_d;
	logic [RUN_CNT_W-1:0] eff_min;
	logic [RUN_CNT_W-1:0] next_count;
	logic                 printable;
	logic                 accept;

	assign accept     = push && !cq_full;
	assign printable  = (item.data_byte inside {[PRINT_LO:PRINT_HI], TAB_CHAR});
	assign next_count = run_count_q + RUN_CNT_W'(1);

	always_comb begin
		if (min_length_q == '0) begin
			eff_min = RUN_CNT_W'(1);
		end else if (32'(min_length_q) > 32'(MAX_MIN_LEN)) begin
			eff_min = RUN_CNT_W'(MAX_MIN_LEN);
		end else begin
			eff_min = RUN_CNT_W'(min_length_q);
		end
	end

	always_comb begin
		run_count_d   = run_count_q;
		emitting_d    = emitting_q;
		byte_offset_d = byte_offset_q;
		cq_push       = 1'b0;
		cq_data.kind  = K_NL;
		cq_data.data  = item.data_byte;
		cq_data.idx   = run_count_q[RUN_IDX_W-1:0];
		cq_data.count = next_count;
		cq_data.offset = byte_offset_q - 32'(run_count_q);
		if (accept) begin
			if (item.cmd == CMD_EOF) begin
				cq_push       = emitting_q;
				emitting_d    = 1'b0;
				run_count_d   = '0;
				byte_offset_d = '0;
			end else begin
				byte_offset_d = byte_offset_q + 32'd1;
				if (!printable) begin
					cq_push     = emitting_q;
					emitting_d  = 1'b0;
					run_count_d = '0;
				end else if (emitting_q) begin
					cq_push      = 1'b1;
					cq_data.kind = K_PASS;
				end else if (next_count >= eff_min) begin
					cq_push      = 1'b1;
					cq_data.kind = K_FLUSH;
					run_count_d  = '0;
					emitting_d   = 1'b1;
				end else begin
					cq_push      = 1'b1;
					cq_data.kind = K_WRITE;
					run_count_d  = next_count;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q  <= DEF_MIN_LEN;
			run_count_q   <= '0;
			emitting_q    <= 1'b0;
			byte_offset_q <= '0;
		end else begin
			if (cfg_valid) begin
				min_length_q <= cfg_data;
			end
			run_count_q   <= run_count_d;
			emitting_q    <= emitting_d;
			byte_offset_q <= byte_offset_d;
		end
	end

endmodule

// ----- rtl/core/pre_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// pre_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pre_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  pre_pkg::work_cmd_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output pre_pkg::work_cmd_t rd_data,
	output logic               empty
);
	import pre_pkg::*;

	work_cmd_t             slots_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] head_q;
	logic [CMDQ_PTR_W-1:0] tail_q;
	logic [CMDQ_PTR_W:0]   count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slots_q[head_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[tail_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				tail_q <= tail_q + CMDQ_PTR_W'(1);
			end
			if (do_rd) begin
				head_q <= head_q + CMDQ_PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (CMDQ_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (CMDQ_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/pre_back.sv -----
// ----------------------------------------------------------------------------
// pre_back
// Executes work commands: run buffer writes, run replay, pass-through and
// newline results, and holds finished results in an output queue.
// ----------------------------------------------------------------------------
module pre_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pre_pkg::work_cmd_t cq_data,
	input  logic               cq_empty,
	output logic               cq_pop,
	output pre_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);
	import pre_pkg::*;

	back_state_t          state_q;
	back_state_t          state_d;

	logic [7:0]           run_mem [MAX_MIN_LEN];
	logic [7:0]           mem_rd_q;
	logic                 mem_wr;
	logic                 mem_rd;

	logic [RUN_IDX_W-1:0] rd_idx_q;
	logic [RUN_IDX_W-1:0] last_idx_q;
	logic [31:0]          flush_off_q;

	logic                 valid_s1;
	logic                 use_mem_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;
	logic [31:0]          offset_s1;
	logic                 last_s1;

	logic                 issue;
	logic                 space;

	out_item_t             oq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] oq_head_q;
	logic [OUTQ_PTR_W-1:0] oq_tail_q;
	logic [OUTQ_PTR_W:0]   oq_count_q;
	logic                  oq_pop;
	out_item_t             oq_in;

	assign space  = ((OUTQ_PTR_W+1)'(oq_count_q) + (OUTQ_PTR_W+1)'(valid_s1))
		< (OUTQ_PTR_W+1)'(OUTQ_DEPTH);
	assign mem_wr = cq_pop && (cq_data.kind == K_WRITE || cq_data.kind == K_FLUSH);

	always_comb begin
		state_d = state_q;
		cq_pop  = 1'b0;
		issue   = 1'b0;
		mem_rd  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!cq_empty) begin
					case (cq_data.kind)
						K_WRITE: cq_pop = 1'b1;
						K_FLUSH: begin
							cq_pop  = 1'b1;
							state_d = BK_FLUSH;
						end
						K_PASS, K_NL: begin
							cq_pop = space;
							issue  = space;
						end
						default: cq_pop = 1'b1;
					endcase
				end
			end
			BK_FLUSH: begin
				if (space) begin
					issue  = 1'b1;
					mem_rd = 1'b1;
					if (rd_idx_q == last_idx_q) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			run_mem[cq_data.idx] <= cq_data.data;
		end
		if (mem_rd) begin
			mem_rd_q <= run_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cq_pop && cq_data.kind == K_FLUSH) begin
			rd_idx_q    <= '0;
			last_idx_q  <= RUN_IDX_W'(cq_data.count - RUN_CNT_W'(1));
			flush_off_q <= cq_data.offset;
		end else if (mem_rd) begin
			rd_idx_q <= rd_idx_q + RUN_IDX_W'(1);
		end
		if (issue) begin
			use_mem_s1 <= mem_rd;
			byte_s1    <= (cq_data.kind == K_NL) ? NEWLINE_CHAR : cq_data.data;
			start_s1   <= mem_rd && (rd_idx_q == '0);
			offset_s1  <= (mem_rd && rd_idx_q == '0) ? flush_off_q : '0;
			last_s1    <= !mem_rd || (rd_idx_q == last_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_comb begin
		oq_in.out_byte      = use_mem_s1 ? mem_rd_q : byte_s1;
		oq_in.string_start  = start_s1;
		oq_in.string_offset = offset_s1;
		oq_in.last          = last_s1;
	end

	assign empty  = (oq_count_q == '0);
	assign oq_pop = pop && !empty;
	assign result = oq_q[oq_head_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			oq_q[oq_tail_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_head_q  <= '0;
			oq_tail_q  <= '0;
			oq_count_q <= '0;
		end else begin
			if (valid_s1) begin
				oq_tail_q <= oq_tail_q + OUTQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_head_q <= oq_head_q + OUTQ_PTR_W'(1);
			end
			case ({valid_s1, oq_pop})
				2'b10:   oq_count_q <= oq_count_q + (OUTQ_PTR_W+1)'(1);
				2'b01:   oq_count_q <= oq_count_q - (OUTQ_PTR_W+1)'(1);
				default: oq_count_q <= oq_count_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/printable_run_extractor.sv -----
// ----------------------------------------------------------------------------
// printable_run_extractor
// Reports runs of printable bytes at least min_length long (0 as 1, over 32 as 32).
// ----------------------------------------------------------------------------
// Input: write an item (cmd, data_byte) with push while full is low; cmd
// marks end of file. Results: while empty is low, result holds the oldest
// output byte; pop takes it. The last result that an input causes has last
// set; the first byte of a reported string carries string_start and its
// offset. Configuration: cfg_valid/cfg_ready write min_length; the user must
// write it only while the block is idle, the block does not enforce this;
// cfg_ready is always high. Throughput: one input byte per cycle while full
// is low. A run that reaches min_length (up to 32 bytes) is replayed from
// the run buffer one byte per cycle while the output queue has space; a
// 4-entry command queue lets the front keep accepting meanwhile. A
// pass-through or newline result passes the command queue, the s1 register
// and the output queue; a replayed byte also goes through the run buffer read
// register. When the receiver stalls, the output queue fills, the back end
// holds, then the command queue fills and full rises. Reset clears all
// queues, run state and offset, and sets min_length to 4; no clearing pass.
// ----------------------------------------------------------------------------
module printable_run_extractor (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pre_pkg::CFG_W-1:0] cfg_data,
	input  logic                      push,
	output logic                      full,
	input  pre_pkg::in_item_t         item,
	output logic                      empty,
	input  logic                      pop,
	output pre_pkg::out_item_t        result
);
	import pre_pkg::*;

	work_cmd_t front_cmd;
	work_cmd_t back_cmd;
	logic      cq_push;
	logic      cq_full;
	logic      cq_pop;
	logic      cq_empty;

	assign cfg_ready = 1'b1;
	assign full      = cq_full;

	pre_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.cq_full   (cq_full),
		.cq_push   (cq_push),
		.cq_data   (front_cmd)
	);

	pre_cmd_fifo u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_push),
		.wr_data (front_cmd),
		.full    (cq_full),
		.rd_en   (cq_pop),
		.rd_data (back_cmd),
		.empty   (cq_empty)
	);

	pre_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_data  (back_cmd),
		.cq_empty (cq_empty),
		.cq_pop   (cq_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

// ----- test/printable_run_extractor_tb.sv -----
// ----------------------------------------------------------------------------
// printable_run_extractor_tb
// Self-checking testbench for the printable run extractor. A driver streams
// bytes and end-of-file markers from a pending queue, a monitor pops results
// and compares each one against a cycle-free model of the string scanner.
// min_length is set between phases to values from 0 up to 63, and both
// sides can insert random gaps.
// ----------------------------------------------------------------------------
module printable_run_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pre_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYC = 16;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             push      = 1'b0;
	logic             full;
	in_item_t         item      = '0;
	logic             empty;
	logic             pop       = 1'b0;
	out_item_t        result;

	// scanner state
	logic [7:0]  str_buf [MAX_MIN_LEN];
	int          pend_len    = 0;
	bit          in_string   = 1'b0;
	logic [31:0] next_ofs    = '0;
	logic [5:0]  min_len_reg = DEF_MIN_LEN;

	in_item_t  byte_q[$];
	out_item_t string_out_q[$];

	int n_queued    = 0;
	int n_items     = 0;
	int n_results   = 0;
	int n_errors    = 0;
	int n_settings  = 0;
	int send_gap    = 0;
	int pop_stall   = 0;
	int idle_cyc    = 0;
	bit send_gaps_en = 1'b1;
	bit pop_stalls_en = 1'b1;

	printable_run_extractor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int clamp_min(logic [5:0] m);
		if (m == 0) return 1;
		if (m > MAX_MIN_LEN) return MAX_MIN_LEN;
		return int'(m);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void scan_byte(in_item_t it);
		out_item_t   o;
		logic [31:0] first_ofs;
		int          n;
		int          i;
		if (it.cmd == CMD_EOF) begin
			if (in_string) begin
				o = '{NEWLINE_CHAR, 1'b0, 32'd0, 1'b1};
				string_out_q.push_back(o);
			end
			in_string = 1'b0;
			pend_len  = 0;
			next_ofs  = '0;
			return;
		end
		if (!((it.data_byte >= PRINT_LO && it.data_byte <= PRINT_HI) ||
				it.data_byte == TAB_CHAR)) begin
			if (in_string) begin
				o = '{NEWLINE_CHAR, 1'b0, 32'd0, 1'b1};
				string_out_q.push_back(o);
			end
			in_string = 1'b0;
			pend_len  = 0;
		end else if (in_string) begin
			o = '{it.data_byte, 1'b0, 32'd0, 1'b1};
			string_out_q.push_back(o);
		end else begin
			first_ofs = next_ofs - 32'(pend_len);
			if (pend_len < MAX_MIN_LEN) str_buf[pend_len] = it.data_byte;
			pend_len++;
			if (pend_len >= clamp_min(min_len_reg)) begin
				n = (pend_len < MAX_MIN_LEN) ? pend_len : MAX_MIN_LEN;
				for (i = 0; i < n; i++) begin
					o.out_byte      = str_buf[i];
					o.string_start  = (i == 0);
					o.string_offset = (i == 0) ? first_ofs : 32'd0;
					o.last          = (i == n - 1);
					string_out_q.push_back(o);
				end
				pend_len  = 0;
				in_string = 1'b1;
			end
		end
		next_ofs = next_ofs + 32'd1;
	endfunction

	// driver: one transfer per accepted item, random gaps between items when enabled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push     <= 1'b0;
			item     <= '0;
			send_gap <= 0;
		end else begin
			if (push && !full) begin
				scan_byte(item);
				n_items++;
			end
			if (!push || !full) begin
				if (send_gap > 0) begin
					push     <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (byte_q.size() > 0) begin
					push <= 1'b1;
					item <= byte_q.pop_front();
					if (send_gaps_en) send_gap <= pick_gap();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transfer against the oldest expected one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop       <= 1'b0;
			pop_stall <= 0;
		end else begin
			if (pop && !empty) begin
				n_results++;
				if (string_out_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result: byte %02h start %0d ofs %08h last %0d",
							result.out_byte, result.string_start, result.string_offset,
							result.last);
				end else if (result !== string_out_q[0]) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch: exp byte %02h start %0d ofs %08h last %0d",
							string_out_q[0].out_byte, string_out_q[0].string_start,
							string_out_q[0].string_offset, string_out_q[0].last);
						$display("          got byte %02h start %0d ofs %08h last %0d",
							result.out_byte, result.string_start, result.string_offset,
							result.last);
					end
					void'(string_out_q.pop_front());
				end else begin
					void'(string_out_q.pop_front());
				end
			end
			if (pop_stall > 0) begin
				pop       <= 1'b0;
				pop_stall <= pop_stall - 1;
			end else begin
				pop <= 1'b1;
				if (pop_stalls_en) pop_stall <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		in_item_t it;
		it.cmd       = CMD_DATA;
		it.data_byte = b;
		byte_q.push_back(it);
		n_queued++;
	endtask

	task automatic queue_eof();
		in_item_t it;
		it.cmd       = CMD_EOF;
		it.data_byte = 8'($urandom_range(0, 255));
		byte_q.push_back(it);
		n_queued++;
	endtask

	function automatic logic [7:0] rand_printable();
		if ($urandom_range(0, 15) == 0) return TAB_CHAR;
		return 8'($urandom_range(PRINT_LO, PRINT_HI));
	endfunction

	function automatic logic [7:0] rand_control();
		int v;
		do begin
			v = $urandom_range(0, 160);
			if (v >= 32) v = 'h7F + (v - 32);
		end while (v == TAB_CHAR);
		return 8'(v);
	endfunction

	task automatic wait_quiet(input int settle);
		while (byte_q.size() > 0 || push || string_out_q.size() > 0) @(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [5:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		min_len_reg = v;
		n_settings++;
	endtask

	task automatic queue_phase(input int n, input int eff);
		int start;
		int len;
		int r;
		int k;
		start = n_queued;
		while (n_queued - start < n) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				queue_byte(8'($urandom_range(0, 255)));
			end else if (r == 1) begin
				queue_eof();
			end else begin
				if ($urandom_range(0, 3) == 0) len = $urandom_range(1, eff);
				else len = $urandom_range(eff, eff + 6);
				for (k = 0; k < len && n_queued - start < n; k++)
					queue_byte(rand_printable());
				if (n_queued - start < n) begin
					r = $urandom_range(0, 9);
					if (r < 8) queue_byte(rand_control());
					else if (r == 8) queue_eof();
				end
			end
		end
	endtask

	initial begin
		logic [5:0] sweep [10];
		int         p;
		sweep = '{6'd32, 6'd63, 6'd1, 6'd33, 6'd5, 6'd2, 6'd16, 6'd0, 6'd4, 6'd3};
		sweep[8] = 6'($urandom_range(0, 63));
		sweep[9] = 6'($urandom_range(1, 12));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short run dropped, end of file with nothing pending
		queue_byte("A"); queue_byte("B"); queue_byte(8'h00);
		queue_eof();
		// printable bounds and tab, then pass-through and close
		queue_byte(PRINT_LO); queue_byte(PRINT_HI); queue_byte(TAB_CHAR); queue_byte("A");
		queue_byte("B");
		queue_byte(8'h7F);
		queue_byte(8'h1F); queue_byte(8'hFF);
		queue_byte("x"); queue_byte("y"); queue_byte("z"); queue_byte("w");
		queue_eof();
		queue_byte(NEWLINE_CHAR); queue_byte(8'h80);
		wait_quiet(SETTLE_CYC);

		write_min_len(6'd0);
		queue_byte("a"); queue_byte(8'h19);
		wait_quiet(SETTLE_CYC);

		// lower the minimum while a run is pending
		write_min_len(6'd8);
		queue_byte("a"); queue_byte("b"); queue_byte("c");
		wait_quiet(SETTLE_CYC);
		write_min_len(6'd2);
		queue_byte("d");
		queue_eof();
		wait_quiet(SETTLE_CYC);

		for (p = 0; p < 10; p++) begin
			write_min_len(sweep[p]);
			case (p)
				1: begin send_gaps_en = 1'b0; pop_stalls_en = 1'b0; end
				2: begin send_gaps_en = 1'b1; pop_stalls_en = 1'b1; end
				default: begin
					send_gaps_en  = 1'($urandom_range(0, 1));
					pop_stalls_en = 1'($urandom_range(0, 1));
				end
			endcase
			queue_phase(22, clamp_min(sweep[p]));
			// hold the sender until every result of the first half is out
			wait_quiet(0);
			queue_phase(21, clamp_min(sweep[p]));
			wait_quiet(SETTLE_CYC);
		end

		wait_quiet(SETTLE_CYC);
		n_errors += string_out_q.size();
		$display("covered %0d input transfers and %0d result transfers", n_items, n_results);
		$display("min_length written %0d times, from 0 up to 63, mismatches %0d",
			n_settings, n_errors);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/pre_pkg.sv
rtl/core/pre_front.sv
rtl/core/pre_cmd_fifo.sv
rtl/core/pre_back.sv
rtl/core/printable_run_extractor.sv
test/printable_run_extractor_tb.sv
